>>> src/lfuvs_pkg.sv
// ----------------------------------------------------------------------------
// lfuvs_pkg: shared types and constants of the LFU victim select unit
// Command codes, victim modes, sequencer states and pressure constants.
// ----------------------------------------------------------------------------
package lfuvs_pkg;

    // Command field of an input item
    typedef enum logic [2:0] {
        CMD_INVALIDATE = 3'd0,
        CMD_TOUCH      = 3'd1,
        CMD_INSERT     = 3'd2,
        CMD_VICTIM     = 3'd3,
        CMD_NOTE_HIT   = 3'd4,
        CMD_NOTE_MISS  = 3'd5
    } cmd_t;

    // Selection mode reported with each victim
    typedef enum logic [1:0] {
        MODE_LEAST = 2'd0,
        MODE_WAY0  = 2'd1,
        MODE_FLUSH = 2'd2
    } mode_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WRITE,
        ST_TOUCH_RD,
        ST_TOUCH_WR,
        ST_PRESS,
        ST_MODE,
        ST_SCAN,
        ST_SCAN_END,
        ST_FLUSH
    } state_t;

    // Configuration register indexes
    localparam logic CFG_LOW_THRESHOLD   = 1'b0;
    localparam logic CFG_FLUSH_THRESHOLD = 1'b1;

    // Pressure counter and thresholds
    localparam int PRESS_W = 11;
    localparam logic [PRESS_W-1:0] PRESSURE_MAX  = 11'd2047;
    localparam logic [PRESS_W-1:0] HIT_DROP      = 11'd2;
    localparam logic [PRESS_W-1:0] LOW_RESET     = 11'd64;
    localparam logic [PRESS_W-1:0] FLUSH_RESET   = 11'd1024;

endpackage

>>> src/adaptive_lfu_victim_select_unit.sv
// ----------------------------------------------------------------------------
// adaptive_lfu_victim_select_unit: LFU replacement with pressure adaptation
// Per-way saturating use counts in a single-port-write memory, a global
// pressure counter driven by hit and miss notes, and a victim sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: an item (cmd, set_index, way) is taken on a rising edge
//   with start high and busy low. Notes (hit, miss) and unused codes leave
//   the unit idle. Invalidate and insert write one count; touch reads it,
//   then writes it back incremented, saturating, through the write port.
//   A victim request runs in fixed way zero mode, flush mode or least count
//   mode; in least count mode the scan reads one way per cycle through the
//   count memory's read port and keeps a running minimum. Its result
//   (victim_way, mode_used) is shown for one cycle with done high, and busy
//   stays high during that cycle; the receiver cannot stall, so the result
//   is taken there and then.
//   Configuration channel: cfg_ready is always high; cfg_index selects low
//   threshold (0) or flush threshold (1). Write only while busy is low.
//   Reset: the count memory is cleared by a pass over all NUM_SETS * 2**WAY_W
//   entries (512 at the defaults) with busy held high; configuration writes
//   are still taken during that pass.
// ----------------------------------------------------------------------------
module adaptive_lfu_victim_select_unit
    import lfuvs_pkg::*;
#(
    parameter int NUM_WAYS   = 8,
    parameter int NUM_SETS   = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         cmd,
    input  logic [5:0]         set_index,
    input  logic [2:0]         way,
    output logic               done,
    output logic [2:0]         victim_way,
    output logic [1:0]         mode_used,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic               cfg_index,
    input  logic [PRESS_W-1:0] cfg_data
);

    localparam int WAY_W  = $clog2(NUM_WAYS);
    localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int ADDR_W = SET_W + WAY_W;
    localparam int DEPTH  = NUM_SETS * (2 ** WAY_W);

    localparam logic [ADDR_W-1:0]     LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [WAY_W-1:0]      LAST_WAY  = WAY_W'(NUM_WAYS - 1);
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;

    // Control state
    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_reg, clr_next;
    logic [WAY_W-1:0]    wcnt_reg, wcnt_next;
    logic [PRESS_W-1:0]  press_reg, press_next;
    logic                last_hit_reg, last_hit_next;
    logic                pend_hit_reg, pend_hit_next;
    logic                pend_miss_reg, pend_miss_next;
    logic [PRESS_W-1:0]  low_thr_reg, flush_thr_reg;
    logic                done_reg, done_next;
    logic                scan_vld_reg, scan_vld_next;

    // Item and result payload
    cmd_t                cmd_reg;
    logic [SET_W-1:0]    set_reg;
    logic [WAY_W-1:0]    way_reg;
    logic                way_ok_reg;
    logic [WAY_W-1:0]    scan_way_reg, scan_way_next;
    logic [COUNT_BITS-1:0] min_reg, min_next;
    logic [WAY_W-1:0]    best_reg, best_next;
    logic [2:0]          victim_reg, victim_next;
    mode_t               mode_reg, mode_next;

    // Count memory
    logic [COUNT_BITS-1:0] mem [DEPTH];
    logic [COUNT_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr;
    logic [COUNT_BITS-1:0] wr_data;

    // Set index wrap table, built at elaboration
    logic [SET_W-1:0] set_lut [64];
    logic [4:0]       way_ext;
    logic             accept;
    logic             over_low, over_flush, cand_better;
    logic [PRESS_W-1:0] press_hit;
    logic             last_hit_mid;

    for (genvar i = 0; i < 64; i++) begin : g_set_lut
        assign set_lut[i] = SET_W'(i % NUM_SETS);
    end

    assign busy       = (state_reg != ST_IDLE) || done_reg;
    assign accept     = start && !busy;
    assign cfg_ready  = 1'b1;
    assign done       = done_reg;
    assign victim_way = victim_reg;
    assign mode_used  = mode_reg;
    assign way_ext    = {2'b00, way};

    assign over_low    = press_reg > low_thr_reg;
    assign over_flush  = press_reg > flush_thr_reg;
    assign cand_better = (scan_way_reg == '0) || (rd_data_reg < min_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (cmd_t'(cmd))
                        CMD_INVALIDATE, CMD_INSERT:
                            state_next = (way_ext < 5'(NUM_WAYS)) ? ST_WRITE : ST_IDLE;
                        CMD_TOUCH:
                            state_next = (way_ext < 5'(NUM_WAYS)) ? ST_TOUCH_RD : ST_IDLE;
                        CMD_VICTIM:
                            state_next = ST_PRESS;
                        default:
                            state_next = ST_IDLE;
                    endcase
                end
            end
            ST_WRITE:    state_next = ST_IDLE;
            ST_TOUCH_RD: state_next = ST_TOUCH_WR;
            ST_TOUCH_WR: state_next = ST_IDLE;
            ST_PRESS:    state_next = ST_MODE;
            ST_MODE:
            begin
                if (over_low && !over_flush)
                    state_next = ST_IDLE;
                else if (over_flush)
                    state_next = ST_FLUSH;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:
            begin
                if (wcnt_reg == LAST_WAY)
                    state_next = ST_SCAN_END;
            end
            ST_SCAN_END: state_next = ST_IDLE;
            ST_FLUSH:
            begin
                if (wcnt_reg == LAST_WAY)
                    state_next = ST_IDLE;
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        clr_next       = clr_reg;
        wcnt_next      = wcnt_reg;
        press_next     = press_reg;
        last_hit_next  = last_hit_reg;
        pend_hit_next  = pend_hit_reg;
        pend_miss_next = pend_miss_reg;
        done_next      = 1'b0;
        scan_vld_next  = 1'b0;
        scan_way_next  = wcnt_reg;
        min_next       = min_reg;
        best_next      = best_reg;
        victim_next    = victim_reg;
        mode_next      = mode_reg;
        rd_addr        = {set_reg, wcnt_reg};
        wr_en          = 1'b0;
        wr_addr        = {set_reg, way_reg};
        wr_data        = '0;
        press_hit      = press_reg;
        last_hit_mid   = last_hit_reg;

        // Track the running minimum of the scan
        if (scan_vld_reg && cand_better)
        begin
            min_next  = rd_data_reg;
            best_next = scan_way_reg;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                wr_addr  = clr_reg;
                clr_next = clr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                wcnt_next = '0;
                if (accept && (cmd_t'(cmd) == CMD_NOTE_HIT))
                    pend_hit_next = 1'b1;
                if (accept && (cmd_t'(cmd) == CMD_NOTE_MISS))
                    pend_miss_next = 1'b1;
            end
            ST_WRITE:
            begin
                wr_en   = 1'b1;
                wr_data = (cmd_reg == CMD_INSERT) ? COUNT_BITS'(1) : '0;
            end
            ST_TOUCH_RD:
            begin
                rd_addr = {set_reg, way_reg};
            end
            ST_TOUCH_WR:
            begin
                wr_en   = 1'b1;
                wr_data = (rd_data_reg == CNT_MAX) ? rd_data_reg : rd_data_reg + 1'b1;
            end
            ST_PRESS:
            begin
                // Apply the pending hit, then the pending miss
                if (pend_hit_reg)
                begin
                    if (last_hit_reg)
                    begin
                        press_hit    = '0;
                        last_hit_mid = 1'b0;
                    end
                    else
                    begin
                        last_hit_mid = 1'b1;
                        if (press_reg > PRESS_W'(1))
                            press_hit = press_reg - HIT_DROP;
                    end
                end
                press_next    = press_hit;
                last_hit_next = last_hit_mid;
                if (pend_miss_reg)
                begin
                    last_hit_next = 1'b0;
                    if (press_hit != PRESSURE_MAX)
                        press_next = press_hit + 1'b1;
                end
                pend_hit_next  = 1'b0;
                pend_miss_next = 1'b0;
            end
            ST_MODE:
            begin
                if (over_low && !over_flush)
                begin
                    done_next   = 1'b1;
                    victim_next = '0;
                    mode_next   = MODE_WAY0;
                end
                else if (over_flush)
                begin
                    done_next   = 1'b1;
                    victim_next = '0;
                    mode_next   = MODE_FLUSH;
                    press_next  = '0;
                end
            end
            ST_SCAN:
            begin
                scan_vld_next = 1'b1;
                wcnt_next     = wcnt_reg + 1'b1;
            end
            ST_SCAN_END:
            begin
                done_next   = 1'b1;
                mode_next   = MODE_LEAST;
                victim_next = 3'(cand_better ? scan_way_reg : best_reg);
            end
            ST_FLUSH:
            begin
                wr_en     = 1'b1;
                wr_addr   = {set_reg, wcnt_reg};
                wcnt_next = wcnt_reg + 1'b1;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            wcnt_reg      <= '0;
            press_reg     <= '0;
            last_hit_reg  <= 1'b0;
            pend_hit_reg  <= 1'b0;
            pend_miss_reg <= 1'b0;
            done_reg      <= 1'b0;
            scan_vld_reg  <= 1'b0;
            low_thr_reg   <= LOW_RESET;
            flush_thr_reg <= FLUSH_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            wcnt_reg      <= wcnt_next;
            press_reg     <= press_next;
            last_hit_reg  <= last_hit_next;
            pend_hit_reg  <= pend_hit_next;
            pend_miss_reg <= pend_miss_next;
            done_reg      <= done_next;
            scan_vld_reg  <= scan_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_LOW_THRESHOLD)
                    low_thr_reg <= cfg_data;
                if (cfg_index == CFG_FLUSH_THRESHOLD)
                    flush_thr_reg <= cfg_data;
            end
        end
    end

    // Payload registers: hold the item and the scan state
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= cmd_t'(cmd);
            set_reg    <= set_lut[set_index];
            way_reg    <= way_ext[WAY_W-1:0];
            way_ok_reg <= way_ext < 5'(NUM_WAYS);
        end
        scan_way_reg <= scan_way_next;
        min_reg      <= min_next;
        best_reg     <= best_next;
        victim_reg   <= victim_next;
        mode_reg     <= mode_next;
    end

    // Count memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en && (way_ok_reg || (state_reg != ST_WRITE && state_reg != ST_TOUCH_WR)))
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

endmodule

>>> src/lfuvs_checker.sv
// ----------------------------------------------------------------------------
// lfuvs_checker: port-level checks of the LFU victim select unit
// Watches the command and result ports and flags sequencing slips.
// ----------------------------------------------------------------------------
module lfuvs_checker
    import lfuvs_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       start,
    input logic       busy,
    input logic [2:0] cmd,
    input logic       done,
    input logic [2:0] victim_way,
    input logic [1:0] mode_used
);

    // A result is shown while the unit still reports busy
    assert property (@(posedge clk) disable iff (!rst_n) done |-> busy)
        else $error("result shown while not busy");

    // Fixed way zero and flush modes always name way zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && mode_used != MODE_LEAST) |-> (victim_way == 3'd0))
        else $error("non-LFU mode returned a way other than zero");

    // Mode code is one of the three defined
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (mode_used == MODE_LEAST || mode_used == MODE_WAY0 ||
                  mode_used == MODE_FLUSH))
        else $error("undefined mode code");

    // One result per request: never two in a row
    assert property (@(posedge clk) disable iff (!rst_n) done |=> !done)
        else $error("result strobe held for two cycles");

    // A non-victim item yields no result in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && cmd != CMD_VICTIM) |=> !done)
        else $error("result after a command that returns none");

endmodule

bind adaptive_lfu_victim_select_unit lfuvs_checker u_lfuvs_checker (.*);
